// ----- src/deq_pkg.sv -----
// Shared types and codes for the double-ended queue unit.
// No dependencies; used by deq_ctrl, deq_dp and the top level.
package deq_pkg;

    // operation codes carried in the input tuser field
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5
    } t_op;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the input transaction
        logic exec;      // run the operation on queue state
        logic load;      // move the result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // output register empty or being drained
    } t_stat;

endpackage

// ----- src/deq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/deq_ctrl.sv -----
// Sequencing state machine for the double-ended queue unit.
// Depends on deq_pkg.
module deq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  deq_pkg::t_stat i_stat,
    output deq_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: n_state = S_RESP;
            S_RESP: if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.load    = (r_state == S_RESP) && i_stat.out_free;

endmodule

// ----- src/deq_dp.sv -----
// Datapath: ring indices, entry count, slot RAM and output register.
// Depends on deq_pkg and deq_ram.
module deq_dp #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  deq_pkg::t_cmd                  i_cmd,
    output deq_pkg::t_stat                 o_stat,
    input  logic [deq_pkg::OP_W-1:0]       i_opcode,
    input  logic [deq_pkg::VALUE_W-1:0]    i_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [deq_pkg::DATA_W-1:0]     o_data,
    output logic [deq_pkg::STATUS_W-1:0]   o_status,
    output logic [deq_pkg::COUNT_W-1:0]    o_count,
    output logic                           o_is_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    // captured transaction
    logic [deq_pkg::OP_W-1:0]    r_op;
    logic [deq_pkg::VALUE_W-1:0] r_value;

    // queue state
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    // per-operation result pieces
    logic [deq_pkg::STATUS_W-1:0] r_st, n_st;
    logic                         r_use_rd, n_use_rd;

    // output register
    logic                          r_out_valid;
    logic [deq_pkg::DATA_W-1:0]    r_data;
    logic [deq_pkg::STATUS_W-1:0]  r_status;
    logic [deq_pkg::COUNT_W-1:0]   r_count_o;
    logic                          r_is_empty;

    logic          we, re;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [WIDTH-1:0] wr_data, rd_data;
    logic [63:0]   sx_value, rd_ext, cnt_ext;
    logic          full, empty;

    assign full  = (r_count == FULL_CNT);
    assign empty = (r_count == '0);

    // pushed word: sign-extend, keep WIDTH bits
    assign sx_value = {{32{r_value[31]}}, r_value};
    assign wr_data  = sx_value[WIDTH-1:0];

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_st     = deq_pkg::ST_OK;
        n_use_rd = 1'b0;
        we       = 1'b0;
        re       = 1'b0;
        wr_addr  = r_tail;
        rd_addr  = r_head;
        unique case (r_op)
            deq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    n_st = deq_pkg::ST_FULL;
                end else begin
                    n_head  = idx_dec(r_head);
                    wr_addr = idx_dec(r_head);
                    we      = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            deq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    n_st = deq_pkg::ST_FULL;
                end else begin
                    wr_addr = r_tail;
                    we      = 1'b1;
                    n_tail  = idx_inc(r_tail);
                    n_count = r_count + 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    n_st = deq_pkg::ST_EMPTY;
                end else begin
                    rd_addr  = r_head;
                    re       = 1'b1;
                    n_use_rd = 1'b1;
                    n_head   = idx_inc(r_head);
                    n_count  = r_count - 1'b1;
                end
            end
            deq_pkg::OP_POP_BACK: begin
                if (empty) begin
                    n_st = deq_pkg::ST_EMPTY;
                end else begin
                    rd_addr  = idx_dec(r_tail);
                    re       = 1'b1;
                    n_use_rd = 1'b1;
                    n_tail   = idx_dec(r_tail);
                    n_count  = r_count - 1'b1;
                end
            end
            deq_pkg::OP_PEEK_FRONT: begin
                if (empty) begin
                    n_st = deq_pkg::ST_EMPTY;
                end else begin
                    rd_addr  = r_head;
                    re       = 1'b1;
                    n_use_rd = 1'b1;
                end
            end
            deq_pkg::OP_PEEK_BACK: begin
                if (empty) begin
                    n_st = deq_pkg::ST_EMPTY;
                end else begin
                    rd_addr  = idx_dec(r_tail);
                    re       = 1'b1;
                    n_use_rd = 1'b1;
                end
            end
            default: ;  // unused codes: no-op, ok status
        endcase
        if (!i_cmd.exec) begin
            n_head  = r_head;
            n_tail  = r_tail;
            n_count = r_count;
            we      = 1'b0;
            re      = 1'b0;
        end
    end

    deq_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_re      (re),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // low 32 bits of the stored word, zero-filled when narrower
    assign rd_ext  = 64'(rd_data);
    assign cnt_ext = 64'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_opcode;
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_st     <= n_st;
            r_use_rd <= n_use_rd;
        end
        if (i_cmd.load) begin
            r_data     <= r_use_rd ? rd_ext[deq_pkg::DATA_W-1:0] : '0;
            r_status   <= r_st;
            r_count_o  <= cnt_ext[deq_pkg::COUNT_W-1:0];
            r_is_empty <= empty;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_data          = r_data;
    assign o_status        = r_status;
    assign o_count         = r_count_o;
    assign o_is_empty      = r_is_empty;

endmodule

// ----- src/double_ended_queue_unit.sv -----
// Top level of the double-ended queue unit: controller plus datapath.
// Depends on deq_pkg, deq_ctrl, deq_dp (and deq_ram below it).
//
// Usage:
//   Slave channel: one transaction is one operation. tuser carries the
//   opcode (push front/back, pop front/back, peek front/back), tdata the
//   word to push (ignored by pops and peeks).
//   Master channel: every operation yields exactly one result transaction
//   with the popped/peeked word, a status (ok, empty, full), the entry
//   count after the operation and an empty flag.
//   Timing: an operation is taken in the idle state, runs on the queue
//   state and slot RAM in the execute state, and its result is loaded
//   into the output register in the response state once that register is
//   free; o_m_axis_tvalid is registered from the load. A new operation is
//   taken only after the previous result is loaded (three-state sequencer).
//   Stall: the output register holds its result while i_m_axis_tready is
//   low; a following operation may be taken and executed but its result
//   waits in the datapath until the output register drains.
//   Reset (i_rst_n low, synchronous) empties the queue (indices and count
//   to zero) and drops any pending result; slot contents are not cleared.
//   A push into a full queue is refused with full status; a pop or peek
//   on an empty queue returns zero with empty status.
module double_ended_queue_unit #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // operation channel
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] opcode
    // result channel
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] data, [36:32] count, [39:37] zero
    output logic [2:0]  o_m_axis_tuser    // [1:0] status, [2] is_empty
);

    deq_pkg::t_cmd  cmd;
    deq_pkg::t_stat stat;

    logic [deq_pkg::DATA_W-1:0]   data;
    logic [deq_pkg::STATUS_W-1:0] status;
    logic [deq_pkg::COUNT_W-1:0]  count;
    logic                         is_empty;

    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    deq_dp #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_opcode    (i_s_axis_tuser),
        .i_value     (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_data      (data),
        .o_status    (status),
        .o_count     (count),
        .o_is_empty  (is_empty)
    );

    assign o_m_axis_tdata = {3'b000, count, data};
    assign o_m_axis_tuser = {is_empty, status};

endmodule

// ----- tb/tb_double_ended_queue_unit.sv -----
// Self-checking testbench for double_ended_queue_unit (push/pop/peek at both ends).
// Depends on deq_pkg and the RTL under src; a built-in deque model predicts each result.
`timescale 1ns / 100ps

module tb_double_ended_queue_unit;

    localparam int DEPTH = 16;
    localparam int IDLE_PCT = 37;

    // opcodes the block treats as no-ops
    localparam logic [2:0] OP_NOP_6 = 3'd6;
    localparam logic [2:0] OP_NOP_7 = 3'd7;

    typedef struct packed {
        logic [deq_pkg::DATA_W-1:0]   data;
        logic [deq_pkg::STATUS_W-1:0] status;
        logic [deq_pkg::COUNT_W-1:0]  count;
        logic                         is_empty;
    } t_deq_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [31:0]        i_s_axis_tdata = '0;   // [31:0] value
    logic [2:0]         i_s_axis_tuser = '0;   // [2:0] opcode
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [39:0]        o_m_axis_tdata;        // [31:0] data, [36:32] count, [39:37] zero
    logic [2:0]         o_m_axis_tuser;        // [1:0] status, [2] is_empty

    // mirror of the queue contents and indices
    logic [deq_pkg::DATA_W-1:0] ring_words [DEPTH];
    logic [3:0]         front_idx;
    logic [3:0]         back_idx;
    int unsigned        fill_level;

    t_deq_result        pending_results[$];
    int unsigned        bad_results = 0;
    bit                 steady_flow = 1'b0;   // both sides stop idling while set

    double_ended_queue_unit #(
        .DEPTH (DEPTH),
        .WIDTH (32)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5ms;
        $display("double_ended_queue_unit regression: fail");
        $finish;
    end

    //------------------------------------------------------------------
    // Deque model: applies one operation to the mirror and returns the
    // result the block must produce for it.
    //------------------------------------------------------------------
    function automatic t_deq_result deque_apply(input logic [2:0] op,
                                                input logic [31:0] val);
        t_deq_result r;
        r.data   = '0;
        r.status = deq_pkg::ST_OK;
        case (op)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                if (fill_level >= DEPTH) begin
                    r.status = deq_pkg::ST_FULL;   // refused, nothing changes
                end else if (op == deq_pkg::OP_PUSH_FRONT) begin
                    front_idx = front_idx - 4'd1;
                    ring_words[front_idx] = val;
                    fill_level++;
                end else begin
                    ring_words[back_idx] = val;
                    back_idx = back_idx + 4'd1;
                    fill_level++;
                end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK,
            deq_pkg::OP_PEEK_FRONT, deq_pkg::OP_PEEK_BACK: begin
                if (fill_level == 0) begin
                    r.status = deq_pkg::ST_EMPTY;
                end else if (op == deq_pkg::OP_POP_FRONT) begin
                    r.data = ring_words[front_idx];
                    front_idx = front_idx + 4'd1;
                    fill_level--;
                end else if (op == deq_pkg::OP_POP_BACK) begin
                    back_idx = back_idx - 4'd1;
                    r.data = ring_words[back_idx];
                    fill_level--;
                end else if (op == deq_pkg::OP_PEEK_FRONT) begin
                    r.data = ring_words[front_idx];
                end else begin
                    r.data = ring_words[back_idx - 4'd1];
                end
            end
            default: ;   // unused opcode: report state only
        endcase
        r.count    = fill_level[deq_pkg::COUNT_W-1:0];
        r.is_empty = (fill_level == 0);
        return r;
    endfunction

    //------------------------------------------------------------------
    // Sender: random gaps, then hold the transaction until accepted.
    // Valid is only lowered by a gap or a drain, so a back-to-back item
    // never sees two assignments in one step.
    //------------------------------------------------------------------
    task automatic send_op(input logic [2:0] op, input logic [31:0] val);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= val;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(deque_apply(op, val));
    endtask

    // hold off the sender until every outstanding result is back
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // push_pct steers the fill level; a few unused opcodes are mixed in
    function automatic logic [2:0] rand_op(input int unsigned push_pct);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 3)
            return $urandom_range(1) ? OP_NOP_7 : OP_NOP_6;
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
        case ($urandom_range(3))
            0: return deq_pkg::OP_POP_FRONT;
            1: return deq_pkg::OP_POP_BACK;
            2: return deq_pkg::OP_PEEK_FRONT;
            default: return deq_pkg::OP_PEEK_BACK;
        endcase
    endfunction

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------
    // reads and no-ops on an empty queue, then a single entry
    task automatic test_empty_and_unused();
        send_op(deq_pkg::OP_POP_FRONT, 32'hDEAD_BEEF);
        send_op(deq_pkg::OP_POP_BACK, 32'h1234_5678);
        send_op(deq_pkg::OP_PEEK_FRONT, 32'h0);
        send_op(deq_pkg::OP_PEEK_BACK, 32'hFFFF_FFFF);
        send_op(OP_NOP_6, 32'h5555_5555);
        send_op(OP_NOP_7, 32'hAAAA_AAAA);
        send_op(deq_pkg::OP_PUSH_BACK, 32'h0000_0005);
        send_op(OP_NOP_6, 32'h0);
        send_op(deq_pkg::OP_POP_FRONT, 32'h0);
    endtask

    // extreme words through both ends, read back in both orders
    task automatic test_value_extremes();
        send_op(deq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
        send_op(deq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_op(deq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
        send_op(deq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
        send_op(deq_pkg::OP_PEEK_FRONT, 32'h0);
        send_op(deq_pkg::OP_PEEK_BACK, 32'h0);
        send_op(deq_pkg::OP_POP_BACK, 32'h0);
        send_op(deq_pkg::OP_POP_FRONT, 32'h0);
        send_op(deq_pkg::OP_POP_FRONT, 32'h0);
        send_op(deq_pkg::OP_POP_BACK, 32'h0);
    endtask

    // fill to capacity, try both pushes on a full queue, drain and overdrain
    task automatic test_full_refusal();
        repeat (DEPTH)
            send_op($urandom_range(1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT,
                    rand_word());
        send_op(deq_pkg::OP_PUSH_FRONT, rand_word());
        send_op(deq_pkg::OP_PUSH_BACK, rand_word());
        send_op(deq_pkg::OP_PEEK_FRONT, 32'h0);
        send_op(deq_pkg::OP_PEEK_BACK, 32'h0);
        repeat (DEPTH)
            send_op($urandom_range(1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT,
                    rand_word());
        send_op(deq_pkg::OP_POP_BACK, 32'h0);
    endtask

    // random mix in blocks with different fill pressure
    task automatic test_random_mix();
        int unsigned bias [8] = '{50, 85, 20, 60, 90, 15, 50, 70};
        for (int blk = 0; blk < 8; blk++) begin
            steady_flow = (blk == 3);   // one long stretch at full rate
            for (int n = 0; n < 100; n++)
                send_op(rand_op(bias[blk]), rand_word());
            if (blk == 4)
                drain_results();
        end
        steady_flow = 1'b0;
    endtask

    //------------------------------------------------------------------
    // Result side: random backpressure and in-order compare
    //------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_deq_result got;
        t_deq_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.data     = o_m_axis_tdata[31:0];
            got.count    = o_m_axis_tdata[36:32];
            got.status   = o_m_axis_tuser[1:0];
            got.is_empty = o_m_axis_tuser[2];
            if (pending_results.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("%0t: result with nothing outstanding: %s",
                             $realtime,
                             $sformatf("data=%h st=%0d cnt=%0d e=%b",
                                       got.data, got.status, got.count, got.is_empty));
            end else begin
                want = pending_results.pop_front();
                if (got.data !== want.data || got.status !== want.status ||
                    got.count !== want.count || got.is_empty !== want.is_empty) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("%0t: mismatch exp data=%h st=%0d cnt=%0d e=%b | %s",
                                 $realtime, want.data, want.status, want.count,
                                 want.is_empty,
                                 $sformatf("got data=%h st=%0d cnt=%0d e=%b",
                                           got.data, got.status, got.count,
                                           got.is_empty));
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------
    initial begin
        front_idx  = '0;
        back_idx   = '0;
        fill_level = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_unused();
        test_value_extremes();
        test_full_refusal();
        test_random_mix();

        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (bad_results == 0 && pending_results.size() == 0) begin
            $display("double_ended_queue_unit regression: pass");
        end else begin
            $display("double_ended_queue_unit regression: fail");
        end
        $finish;
    end

endmodule
